### sv/fvr_pkg.sv
`timescale 1ns / 1ps
// Package of the fp64 vector reduction unit: mode codes, binary64 constants,
// unpacked operand types and the binary64 add, compare and rounding functions.
// No dependencies.
package fvr_pkg;

	typedef logic [63:0] f64_t;

	localparam logic [1:0] MODE_SUM = 2'd0;
	localparam logic [1:0] MODE_MAX = 2'd1;
	localparam logic [1:0] MODE_DOT = 2'd2;

	localparam f64_t BITS_LOWEST = 64'hFFEF_FFFF_FFFF_FFFF;
	localparam f64_t BITS_QNAN   = 64'h7FF8_0000_0000_0000;
	localparam logic [62:0] MAG_INF = 63'h7FF0_0000_0000_0000;

	// One operand taken apart, with subnormals normalized so that mant[52] is set.
	typedef struct packed {
		logic               sign;
		logic               zero;
		logic               inf;
		logic               nan;
		logic signed [12:0] exp;
		logic [52:0]        mant;
	} fvr_unp_t;

	// Special classes of a product.
	typedef struct packed {
		logic nan;
		logic inf;
		logic zero;
	} fvr_pspec_t;

	function automatic logic is_nan(input f64_t x);
		return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
	endfunction

	function automatic f64_t start_value(input logic [1:0] mode);
		return (mode == MODE_MAX) ? BITS_LOWEST : 64'd0;
	endfunction

	// Leading zero count of a 56-bit word; a zero word gives 56.
	function automatic logic [5:0] lzc56(input logic [55:0] v);
		logic [5:0] n;
		n = 6'd56;
		for (int i = 0; i < 56; i++) begin
			if (v[i]) begin
				n = 6'(55 - i);
			end
		end
		return n;
	endfunction

	// True when a is strictly greater than b; any NaN compares false.
	function automatic logic fp_gt(input f64_t a, input f64_t b);
		if (is_nan(a) || is_nan(b)) begin
			return 1'b0;
		end
		if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
			return 1'b0;
		end
		if (!a[63] && b[63]) begin
			return 1'b1;
		end
		if (a[63] && !b[63]) begin
			return 1'b0;
		end
		if (!a[63]) begin
			return a[62:0] > b[62:0];
		end
		return a[62:0] < b[62:0];
	endfunction

	function automatic fvr_unp_t fp_unpack(input f64_t x);
		fvr_unp_t   u;
		logic [52:0] m53;
		logic [5:0]  lz;
		m53    = {x[62:52] != 11'd0, x[51:0]};
		lz     = lzc56({m53, 3'b000});
		u.sign = x[63];
		u.nan  = is_nan(x);
		u.inf  = (x[62:0] == MAG_INF);
		u.zero = (x[62:0] == 63'd0);
		if (x[62:52] == 11'd0) begin
			u.mant = m53 << lz;
			u.exp  = 13'sd1 - $signed({7'd0, lz});
		end else begin
			u.mant = m53;
			u.exp  = $signed({2'b00, x[62:52]});
		end
		return u;
	endfunction

	// Rounds to nearest even and packs. m holds 53 significand bits with the
	// leading one at bit 55, then guard, round and sticky. A leading zero after
	// rounding means a subnormal result, which is only possible at exponent one.
	function automatic f64_t round_pack(input logic s, input logic [12:0] e,
			input logic [55:0] m);
		logic        inc;
		logic [53:0] r;
		logic [52:0] mf;
		logic [12:0] ef;
		inc = m[2] & ((|m[1:0]) | m[3]);
		r   = {1'b0, m[55:3]} + 54'(inc);
		if (r[53]) begin
			mf = r[53:1];
			ef = e + 13'd1;
		end else begin
			mf = r[52:0];
			ef = e;
		end
		if (mf[52] && (ef >= 13'd2047)) begin
			return {s, 11'h7FF, 52'd0};
		end
		return {s, mf[52] ? ef[10:0] : 11'd0, mf[51:0]};
	endfunction

	// Binary64 addition with round to nearest even; every NaN result is canonical.
	function automatic f64_t fp_add(input f64_t x, input f64_t y);
		logic        xi;
		logic        yi;
		f64_t        big;
		f64_t        sml;
		logic [11:0] eb;
		logic [11:0] es;
		logic [11:0] d12;
		logic [11:0] eb_m1;
		logic [55:0] mb;
		logic [55:0] ms;
		logic [55:0] msh;
		logic [55:0] mask;
		logic [56:0] sum;
		logic [55:0] m;
		logic [12:0] e;
		logic [5:0]  lz;
		logic [5:0]  sh;
		xi = (x[62:0] == MAG_INF);
		yi = (y[62:0] == MAG_INF);
		if (is_nan(x) || is_nan(y)) begin
			return BITS_QNAN;
		end
		if (xi && yi) begin
			return (x[63] == y[63]) ? x : BITS_QNAN;
		end
		if (xi) begin
			return x;
		end
		if (yi) begin
			return y;
		end
		if (y[62:0] > x[62:0]) begin
			big = y;
			sml = x;
		end else begin
			big = x;
			sml = y;
		end
		eb    = (big[62:52] == 11'd0) ? 12'd1 : {1'b0, big[62:52]};
		es    = (sml[62:52] == 11'd0) ? 12'd1 : {1'b0, sml[62:52]};
		mb    = {big[62:52] != 11'd0, big[51:0], 3'b000};
		ms    = {sml[62:52] != 11'd0, sml[51:0], 3'b000};
		d12   = eb - es;
		eb_m1 = eb - 12'd1;
		mask  = ~({56{1'b1}} << d12);
		if (d12 >= 12'd56) begin
			msh = {55'd0, |ms};
		end else begin
			msh = (ms >> d12) | {55'd0, |(ms & mask)};
		end
		e = {1'b0, eb};
		if (big[63] == sml[63]) begin
			sum = {1'b0, mb} + {1'b0, msh};
			if (sum[56]) begin
				m = {sum[56:2], |sum[1:0]};
				e = e + 13'd1;
			end else begin
				m = sum[55:0];
			end
			return round_pack(big[63], e, m);
		end
		m = mb - msh;
		if (m == 56'd0) begin
			return 64'd0;
		end
		lz = lzc56(m);
		sh = ({6'd0, lz} < eb_m1) ? lz : eb_m1[5:0];
		m  = m << sh;
		e  = e - {7'd0, sh};
		return round_pack(big[63], e, m);
	endfunction

endpackage

### sv/fvr_if.sv
`timescale 1ns / 1ps
// Stream interfaces of the fp64 vector reduction unit: the element channel and
// the result channel. Depends on nothing.
interface fvr_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] elem_a;
	logic [63:0] elem_b;
	logic        last_elem;

	modport source (output valid, output elem_a, output elem_b, output last_elem,
		input ready);
	modport sink (input valid, input elem_a, input elem_b, input last_elem,
		output ready);
endinterface

interface fvr_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] reduced_value;

	modport source (output valid, output reduced_value, input ready);
	modport sink (input valid, input reduced_value, output ready);
endinterface

### sv/fp64_vector_reduction_unit_top.sv
`timescale 1ns / 1ps
// Top level of the fp64 vector reduction unit.
// Depends on fvr_pkg and on the interfaces in fvr_if.sv.

// The unit reduces a stream of IEEE-754 binary64 elements to one binary64
// value: the sum of a, the maximum of a, or the dot product of a and b, as set
// by the two-bit mode register (codes sum, max, dot; the unused fourth code acts
// as sum). It takes one element transaction in every clock cycle while the
// output is not held, and returns one result transaction for each element
// marked last. A last element passes six stages before the accumulator and
// then the output register; in dot mode the stages hold the input operands,
// their unpacking, four partial products of at most 27 by 27 bits, their sum,
// the normalized product and the rounded product. The accumulate itself, one
// binary64 add or compare with round to nearest even on the running value,
// is a combinational step and is what limits the clock. When a result waits
// in the output register and the sink is not ready, the whole pipe holds and
// the input stops taking transactions. A write of the mode register starts a
// new vector and must only happen while the unit is empty. NaN sums and dot
// products come out as the canonical quiet NaN; in max mode NaN elements are
// skipped and the running value starts at the most negative finite double.
module fp64_vector_reduction_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	fvr_in_if.sink      in_ch,
	fvr_out_if.source   out_ch
);

	logic                 dot_mode;
	logic [1:0]           reduce_mode_q;
	fvr_pkg::f64_t        acc_q;
	logic                 out_vld_q;
	fvr_pkg::f64_t        res_q;
	logic                 adv;

	// Stage valids and last marks.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;

	// Element a rides along for sum and max mode.
	fvr_pkg::f64_t a_s1, a_s2, a_s3, a_s4, a_s5, a_s6;
	fvr_pkg::f64_t b_s1;

	fvr_pkg::fvr_unp_t    ua_s2, ub_s2;
	logic [53:0]          pp_hh_s3;
	logic [52:0]          pp_hl_s3, pp_lh_s3;
	logic [51:0]          pp_ll_s3;
	logic                 sign_s3, sign_s4, sign_s5;
	logic signed [12:0]   exp_s3, exp_s4;
	fvr_pkg::fvr_pspec_t  spec_s3, spec_s4, spec_s5;
	logic [105:0]         prod_s4;
	logic [55:0]          m_s5;
	logic [12:0]          e_s5;
	fvr_pkg::f64_t        prod_s6;

	// Combinational values between stages.
	fvr_pkg::fvr_unp_t    ua_c, ub_c;
	logic [105:0]         psum_c;
	logic signed [12:0]   en_c;
	logic signed [12:0]   shamt_c;
	logic [105:0]         pn_c;
	logic [55:0]          m56_c;
	logic [55:0]          mask_c;
	logic [55:0]          mden_c;
	logic [12:0]          eden_c;
	fvr_pkg::f64_t        prod_c;
	fvr_pkg::f64_t        oper_c;
	fvr_pkg::f64_t        next_acc_c;

	// The pipe moves whenever the output register is free or being emptied.
	assign adv          = !out_vld_q || out_ch.ready;
	assign in_ch.ready  = adv;
	assign out_ch.valid = out_vld_q;
	assign out_ch.reduced_value = res_q;
	assign dot_mode     = (reduce_mode_q == fvr_pkg::MODE_DOT);

	always_comb begin
		ua_c = fvr_pkg::fp_unpack(a_s1);
		ub_c = fvr_pkg::fp_unpack(b_s1);
	end

	// Product of the two 53-bit significands from its four partial products.
	assign psum_c = (106'(pp_hh_s3) << 52)
		+ ((106'(pp_hl_s3) + 106'(pp_lh_s3)) << 26)
		+ 106'(pp_ll_s3);

	// Normalize the product to a leading one at bit 105, then shift a result
	// below the normal range right into subnormal position, keeping a sticky bit.
	always_comb begin
		if (prod_s4[105]) begin
			en_c = exp_s4 + 13'sd1;
			pn_c = prod_s4;
		end else begin
			en_c = exp_s4;
			pn_c = prod_s4 << 1;
		end
		m56_c   = {pn_c[105:53], pn_c[52], pn_c[51], |pn_c[50:0]};
		shamt_c = 13'sd1 - en_c;
		mask_c  = ~({56{1'b1}} << shamt_c[5:0]);
		if (en_c >= 13'sd1) begin
			mden_c = m56_c;
			eden_c = en_c;
		end else if (shamt_c >= 13'sd56) begin
			mden_c = {55'd0, |m56_c};
			eden_c = 13'd1;
		end else begin
			mden_c = (m56_c >> shamt_c[5:0]) | {55'd0, |(m56_c & mask_c)};
			eden_c = 13'd1;
		end
	end

	always_comb begin
		if (spec_s5.nan) begin
			prod_c = fvr_pkg::BITS_QNAN;
		end else if (spec_s5.inf) begin
			prod_c = {sign_s5, fvr_pkg::MAG_INF};
		end else if (spec_s5.zero) begin
			prod_c = {sign_s5, 63'd0};
		end else begin
			prod_c = fvr_pkg::round_pack(sign_s5, e_s5, m_s5);
		end
	end

	// The accumulate step: one add or compare against the running value.
	always_comb begin
		oper_c = dot_mode ? prod_s6 : a_s6;
		if (reduce_mode_q == fvr_pkg::MODE_MAX) begin
			next_acc_c = fvr_pkg::fp_gt(a_s6, acc_q) ? a_s6 : acc_q;
		end else begin
			next_acc_c = fvr_pkg::fp_add(acc_q, oper_c);
		end
	end

	// Control state: valids, mode register and running value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			vld_s3        <= 1'b0;
			vld_s4        <= 1'b0;
			vld_s5        <= 1'b0;
			vld_s6        <= 1'b0;
			out_vld_q     <= 1'b0;
			reduce_mode_q <= fvr_pkg::MODE_SUM;
			acc_q         <= fvr_pkg::start_value(fvr_pkg::MODE_SUM);
		end else begin
			if (adv) begin
				vld_s1 <= in_ch.valid;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3;
				vld_s5 <= vld_s4;
				vld_s6 <= vld_s5;
				out_vld_q <= vld_s6 && last_s6;
			end
			if (cfg_we) begin
				reduce_mode_q <= cfg_wdata;
				acc_q         <= fvr_pkg::start_value(cfg_wdata);
			end else if (adv && vld_s6) begin
				acc_q <= last_s6 ? fvr_pkg::start_value(reduce_mode_q) : next_acc_c;
			end
		end
	end

	// Payload registers of the pipe.
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1    <= in_ch.elem_a;
			b_s1    <= in_ch.elem_b;
			last_s1 <= in_ch.last_elem;

			a_s2    <= a_s1;
			last_s2 <= last_s1;
			ua_s2   <= ua_c;
			ub_s2   <= ub_c;

			a_s3     <= a_s2;
			last_s3  <= last_s2;
			pp_hh_s3 <= 54'(ua_s2.mant[52:26]) * 54'(ub_s2.mant[52:26]);
			pp_hl_s3 <= 53'(ua_s2.mant[52:26]) * 53'(ub_s2.mant[25:0]);
			pp_lh_s3 <= 53'(ua_s2.mant[25:0]) * 53'(ub_s2.mant[52:26]);
			pp_ll_s3 <= 52'(ua_s2.mant[25:0]) * 52'(ub_s2.mant[25:0]);
			sign_s3  <= ua_s2.sign ^ ub_s2.sign;
			exp_s3   <= ua_s2.exp + ub_s2.exp - 13'sd1023;
			spec_s3.nan  <= ua_s2.nan || ub_s2.nan || (ua_s2.inf && ub_s2.zero)
				|| (ua_s2.zero && ub_s2.inf);
			spec_s3.inf  <= ua_s2.inf || ub_s2.inf;
			spec_s3.zero <= ua_s2.zero || ub_s2.zero;

			a_s4    <= a_s3;
			last_s4 <= last_s3;
			prod_s4 <= psum_c;
			sign_s4 <= sign_s3;
			exp_s4  <= exp_s3;
			spec_s4 <= spec_s3;

			a_s5    <= a_s4;
			last_s5 <= last_s4;
			m_s5    <= mden_c;
			e_s5    <= eden_c;
			sign_s5 <= sign_s4;
			spec_s5 <= spec_s4;

			a_s6    <= a_s5;
			last_s6 <= last_s5;
			prod_s6 <= prod_c;

			if (vld_s6 && last_s6) begin
				res_q <= next_acc_c;
			end
		end
	end

`ifndef SYNTHESIS
	// A last element leaving the final stage always lands in the output register.
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && last_s6 && adv && !cfg_we |=> out_vld_q)
		else $error("last element did not produce a result");

	// A mode write restarts the running value at the start value of the new mode.
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> acc_q == fvr_pkg::start_value(reduce_mode_q))
		else $error("running value not restarted by mode write");

	// In max mode the running value is never a NaN.
	a_max_no_nan: assert property (@(posedge clk) disable iff (!arst_n)
		reduce_mode_q == fvr_pkg::MODE_MAX |-> !fvr_pkg::is_nan(acc_q))
		else $error("NaN held as running maximum");

	// While the pipe holds, the final stage keeps its item.
	a_hold_s6: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s6))
		else $error("final stage changed during a hold");

	// A sum or dot result never carries a NaN payload other than the canonical one.
	a_canon_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && fvr_pkg::is_nan(res_q) |-> res_q == fvr_pkg::BITS_QNAN)
		else $error("non-canonical NaN result");
`endif

endmodule

### tb/sv/tb_fp64_vector_reduction_unit_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of fp64_vector_reduction_unit_top: sum, max and dot
// reductions checked against a binary64 model kept in the bench.
// Depends on fvr_pkg, the stream interfaces in fvr_if.sv and the RTL top level.
module tb_fp64_vector_reduction_unit_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES = 400;

	// The fourth mode code, which has no reduction of its own.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam fvr_pkg::f64_t F_PZERO   = 64'h0000_0000_0000_0000;
	localparam fvr_pkg::f64_t F_NZERO   = 64'h8000_0000_0000_0000;
	localparam fvr_pkg::f64_t F_PINF    = 64'h7FF0_0000_0000_0000;
	localparam fvr_pkg::f64_t F_NINF    = 64'hFFF0_0000_0000_0000;
	localparam fvr_pkg::f64_t F_SNAN    = 64'h7FF0_0000_0000_1234;
	localparam fvr_pkg::f64_t F_NNAN    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam fvr_pkg::f64_t F_MAX     = 64'h7FEF_FFFF_FFFF_FFFF;
	localparam fvr_pkg::f64_t F_SUBMIN  = 64'h0000_0000_0000_0001;
	localparam fvr_pkg::f64_t F_SUBMAX  = 64'h000F_FFFF_FFFF_FFFF;
	localparam fvr_pkg::f64_t F_NORMMIN = 64'h0010_0000_0000_0000;
	localparam fvr_pkg::f64_t F_ONE     = 64'h3FF0_0000_0000_0000;
	localparam fvr_pkg::f64_t F_NTWO    = 64'hC000_0000_0000_0000;
	localparam fvr_pkg::f64_t F_HALF    = 64'h3FE0_0000_0000_0000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_wdata;

	fvr_in_if  in_ch ();
	fvr_out_if out_ch ();

	fp64_vector_reduction_unit_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source)
	);

	// Bench copy of the unit's state, updated at every accepting clock edge.
	logic [1:0]    model_mode;
	fvr_pkg::f64_t model_acc;
	fvr_pkg::f64_t pending_results[$];

	int  fail_count;
	int  cycle_count;
	bit  tx_calm;
	bit  rx_calm;
	bit  hold_request;
	int  hold_left;
	int  stall_left;

	always #2 clk = ~clk;

	// Starting value of the accumulator; the unused mode code acts as sum.
	function automatic fvr_pkg::f64_t acc_seed(input logic [1:0] mode);
		return (mode == fvr_pkg::MODE_MAX) ? fvr_pkg::BITS_LOWEST : F_PZERO;
	endfunction

	function automatic bit is_nan_bits(input fvr_pkg::f64_t x);
		return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
	endfunction

	function automatic fvr_pkg::f64_t quiet_canon(input fvr_pkg::f64_t x);
		return is_nan_bits(x) ? fvr_pkg::BITS_QNAN : x;
	endfunction

	// Strict greater-than over binary64 patterns. The patterns are mapped to
	// monotonic unsigned keys; signed zeros compare equal and NaN never wins.
	function automatic bit f64_greater(input fvr_pkg::f64_t a, input fvr_pkg::f64_t b);
		fvr_pkg::f64_t ka;
		fvr_pkg::f64_t kb;
		ka = a[63] ? ~a : {1'b1, a[62:0]};
		kb = b[63] ? ~b : {1'b1, b[62:0]};
		if (is_nan_bits(a) || is_nan_bits(b)) begin
			return 1'b0;
		end
		if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
			return 1'b0;
		end
		return ka > kb;
	endfunction

	// Folds one accepted element into the running value. The host's doubles
	// round to nearest even; the product is held in its own variable so that
	// it is rounded before the add.
	task automatic fold_element(input fvr_pkg::f64_t a, input fvr_pkg::f64_t b,
			input logic last);
		real acc_r;
		real prod_r;
		real sum_r;
		acc_r = $bitstoreal(model_acc);
		if (model_mode == fvr_pkg::MODE_MAX) begin
			if (f64_greater(a, model_acc)) begin
				model_acc = a;
			end
		end else if (model_mode == fvr_pkg::MODE_DOT) begin
			prod_r = $bitstoreal(a) * $bitstoreal(b);
			sum_r = acc_r + prod_r;
			model_acc = quiet_canon($realtobits(sum_r));
		end else begin
			sum_r = acc_r + $bitstoreal(a);
			model_acc = quiet_canon($realtobits(sum_r));
		end
		if (last) begin
			pending_results.push_back(model_acc);
			model_acc = acc_seed(model_mode);
		end
	endtask

	// Input monitor: register writes and accepted element transactions.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				model_mode = cfg_wdata;
				model_acc = acc_seed(cfg_wdata);
			end
			if (in_ch.valid && in_ch.ready) begin
				fold_element(in_ch.elem_a, in_ch.elem_b, in_ch.last_elem);
			end
		end
	end

	// Result checker: every accepted result transaction must match the
	// oldest expected value bit for bit.
	always @(posedge clk) begin
		fvr_pkg::f64_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction, reduced_value = %h",
					out_ch.reduced_value);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.reduced_value !== want) begin
					$error("reduced_value mismatch: expected %h, actual %h",
						want, out_ch.reduced_value);
					fail_count++;
				end
			end
		end
	end

	// Result sink. Random stalls, mostly short with a few long ones; a hold
	// request from a test turns into one long hold-off counted here.
	always @(posedge clk) begin
		int r;
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (rx_calm) begin
			out_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b0;
				stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** fp64_vector_reduction_unit_top: FAILED **");
			$finish;
		end
	end

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (tx_calm || r < 60) begin
			return 0;
		end
		return (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	// Offers one element transaction and returns at the edge that accepts it.
	// The valid stays high into the next call when no gap follows, so it is
	// never lowered and raised within one time step.
	task automatic send_elem(input fvr_pkg::f64_t a, input fvr_pkg::f64_t b,
			input logic last);
		int gap;
		gap = gap_cycles();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.elem_a <= a;
		in_ch.elem_b <= b;
		in_ch.last_elem <= last;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
	endtask

	// Drops valid, waits for every expected result and then for the pipe
	// latency, so the unit is empty before a register write.
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] mode);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Random binary64 pattern: specials, fully random bits, and values near one
	// whose sums and products stay meaningful.
	function automatic fvr_pkg::f64_t random_f64();
		fvr_pkg::f64_t specials[11];
		int r;
		specials = '{F_PZERO, F_NZERO, F_PINF, F_NINF, F_SNAN, F_NNAN, F_MAX,
			fvr_pkg::BITS_LOWEST, F_SUBMIN, F_SUBMAX, F_NORMMIN};
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return specials[$urandom_range(0, 10)];
		end
		if (r < 4) begin
			return {$urandom(), $urandom()};
		end
		return {1'($urandom_range(0, 1)), 11'($urandom_range(1013, 1033)),
			20'($urandom_range(0, 20'hFFFFF)), $urandom()};
	endfunction

	// One vector of random length, mostly short, with random contents.
	task automatic send_random_vector(inout int sent);
		int len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		for (int i = 0; i < len; i++) begin
			send_elem(random_f64(), random_f64(), i == len - 1);
		end
		sent += len;
	endtask

	task automatic random_phase(input logic [1:0] mode, input int items);
		int sent;
		sent = 0;
		write_mode(mode);
		while (sent < items) begin
			tx_calm = ($urandom_range(0, 7) == 0);
			rx_calm = ($urandom_range(0, 7) == 0);
			send_random_vector(sent);
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		settle();
	endtask

	// Sum: signed zeros, overflow to infinity, infinities that cancel into a
	// NaN, a NaN with a payload, and subnormals.
	task automatic test_sum_edges();
		write_mode(fvr_pkg::MODE_SUM);
		send_elem(F_NZERO, F_PZERO, 1'b1);
		send_elem(F_MAX, F_PZERO, 1'b0);
		send_elem(F_MAX, F_PZERO, 1'b1);
		send_elem(F_PINF, F_PZERO, 1'b0);
		send_elem(F_NINF, F_PZERO, 1'b1);
		send_elem(F_SNAN, F_PZERO, 1'b0);
		send_elem(F_ONE, F_PZERO, 1'b1);
		send_elem(F_SUBMAX, F_PZERO, 1'b0);
		send_elem(F_SUBMIN, F_PZERO, 1'b1);
		settle();
	endtask

	// Max: NaN elements are skipped, negative infinity and NaNs alone give the
	// lowest finite value, and between zeros the held value stays.
	task automatic test_max_edges();
		write_mode(fvr_pkg::MODE_MAX);
		send_elem(F_NINF, F_PZERO, 1'b0);
		send_elem(F_NNAN, F_PZERO, 1'b1);
		send_elem(F_NZERO, F_PZERO, 1'b0);
		send_elem(F_PZERO, F_PZERO, 1'b1);
		send_elem(F_SNAN, F_PZERO, 1'b0);
		send_elem(F_NTWO, F_PZERO, 1'b0);
		send_elem(F_PINF, F_PZERO, 1'b1);
		settle();
	endtask

	// Dot: infinity times zero, a product that overflows, and one that
	// underflows into the subnormal range.
	task automatic test_dot_edges();
		write_mode(fvr_pkg::MODE_DOT);
		send_elem(F_PINF, F_NZERO, 1'b1);
		send_elem(F_MAX, F_NTWO, 1'b1);
		send_elem(F_NORMMIN, F_HALF, 1'b0);
		send_elem(F_ONE, F_ONE, 1'b1);
		settle();
	endtask

	// The unused mode code must behave as sum.
	task automatic test_spare_mode();
		write_mode(MODE_UNUSED);
		send_elem(F_ONE, F_MAX, 1'b0);
		send_elem(F_HALF, F_MAX, 1'b1);
		settle();
	endtask

	// Long hold-off at the result side while the sender keeps offering short
	// vectors, so the pipe fills and the input stalls.
	task automatic test_backpressure();
		int sent;
		sent = 0;
		write_mode(fvr_pkg::MODE_DOT);
		tx_calm = 1'b1;
		hold_request = 1'b1;
		for (int i = 0; i < 60; i++) begin
			send_elem(random_f64(), random_f64(), 1'($urandom_range(0, 1)));
		end
		send_elem(F_ONE, F_ONE, 1'b1);
		tx_calm = 1'b0;
		settle();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = fvr_pkg::MODE_SUM;
		in_ch.valid = 1'b0;
		in_ch.elem_a = '0;
		in_ch.elem_b = '0;
		in_ch.last_elem = 1'b0;
		out_ch.ready = 1'b0;
		model_mode = fvr_pkg::MODE_SUM;
		model_acc = acc_seed(fvr_pkg::MODE_SUM);
		fail_count = 0;
		cycle_count = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		stall_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sum_edges();
		test_max_edges();
		test_dot_edges();
		test_spare_mode();
		test_backpressure();
		random_phase(fvr_pkg::MODE_SUM, 340);
		random_phase(fvr_pkg::MODE_MAX, 340);
		random_phase(fvr_pkg::MODE_DOT, 340);
		random_phase(MODE_UNUSED, 340);

		if (fail_count == 0) begin
			$display("** fp64_vector_reduction_unit_top: PASSED **");
		end else begin
			$display("** fp64_vector_reduction_unit_top: FAILED **");
		end
		$finish;
	end

endmodule
